[hw/rtl/best_fit_slot_allocator_core_assert.svh]
// assertion macros used by the allocator core rtl
`ifndef BEST_FIT_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define BEST_FIT_SLOT_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define BFSA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/bfsa_pkg.sv]
// shared types and constants of the best-fit slot allocator
package bfsa_pkg;

   localparam int OPCODE_W    = 3;
   localparam int SIZE_W      = 32;
   localparam int ID_W        = 32;
   localparam int STATUS_W    = 3;
   localparam int GID_W       = 9;
   localparam int OFFSET_W    = 24;
   localparam int STAMP_W     = 32;
   localparam int SHIFT_W     = 5;
   localparam int TOTAL_W     = 9;
   localparam int SHIFT_MAX   = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 40;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOCATE = 3'd0,
      OP_RETIRE   = 3'd1,
      OP_ACQUIRE  = 3'd2,
      OP_RELEASE  = 3'd3,
      OP_COALESCE = 3'd4,
      OP_CLEAR    = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_ZERO_SIZE  = 3'd1,
      ST_REALLOC    = 3'd2,
      ST_INVALID_ID = 3'd3,
      ST_COUNT_ZERO = 3'd4
   } status_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_SHIFT  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL_UNITS = 1'b1;

endpackage

[hw/rtl/bfsa_slot_ram.sv]
// slot table memory, one write port and one registered read port
module bfsa_slot_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[hw/rtl/best_fit_slot_allocator_core.sv]
// best-fit slot allocator: top level with sequencer over the slot table
//
// one beat on req_ carries an operation (allocate, retire, acquire, release,
// coalesce, clear); exactly one beat comes back on rsp_ for each of them.
// csr_ writes slot_shift (index 0) and total_units (index 1), idle only;
// the user must keep to this, the block itself does not enforce it.
// allocate scans every slot table entry through the single read port (the
// scan reads one entry a cycle), then writes the best fit, if any, and,
// when a remainder is split off, a new free block; retire, acquire and
// release read the entry and update it; a zero size or an id out of range
// is answered without a table access; coalesce skips busy blocks, merges
// each free run into its head block; clear writes one entry a cycle.
// after reset the table is swept once with req_tready low;
// config writes are taken during that sweep.
// one item at a time; the result sits in an output register, so a new beat
// is accepted while rsp_tvalid waits on a stalled receiver, but the next
// result is held back until the pending one is taken.
module best_fit_slot_allocator_core #(
   parameter int MAX_SLOTS   = 256,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // opcode[2:0], request_size[34:3], block_id[66:35], zero fill
   input  logic [bfsa_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // status[2:0], granted_id[11:3], granted_offset[35:12], zero fill
   output logic [bfsa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [bfsa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bfsa_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bfsa_pkg::*;

`include "best_fit_slot_allocator_core_assert.svh"

   localparam int AW = $clog2(MAX_SLOTS);
   localparam int LW = AW + 1;

   // one slot table entry
   typedef struct packed {
      logic                   head;
      logic                   alloc;
      logic                   infree;
      logic [COUNT_WIDTH-1:0] use_cnt;
      logic [LW-1:0]          len;
      logic [STAMP_W-1:0]     stamp;
   } entry_type;

   localparam int EW = $bits(entry_type);

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_SCAN,
      S_ALLOC_BEST,
      S_ALLOC_SPLIT,
      S_ID,
      S_COAL_S,
      S_COAL_NX,
      S_COAL_FIN,
      S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [SHIFT_W-1:0]      slot_shift_ff, slot_shift_in;
   logic [TOTAL_W-1:0]      total_units_ff, total_units_in;
   logic [STAMP_W-1:0]      stamp_ff, stamp_in;
   logic [AW-1:0]           idx_ff, idx_in;       // sweep and scan index
   logic                    sweep_rsp_ff, sweep_rsp_in;
   logic [SIZE_W:0]         units_ff, units_in;
   logic                    found_ff, found_in;
   logic [AW-1:0]           best_idx_ff, best_idx_in;
   entry_type               best_ff, best_in;     // also the block head in coalesce
   logic [LW-1:0]           ns_ff, ns_in;
   opcode_type              op_ff, op_in;
   logic [AW-1:0]           slot_ff, slot_in;
   logic [LW-1:0]           s_ff, s_in;
   logic [LW-1:0]           nx_ff, nx_in;
   logic [LW-1:0]           acc_ff, acc_in;
   logic                    merged_ff, merged_in;
   status_type              res_status_ff, res_status_in;
   logic [GID_W-1:0]        res_gid_ff, res_gid_in;
   logic [OFFSET_W-1:0]     res_off_ff, res_off_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                    ram_wr_en;
   logic [AW-1:0]           ram_wr_addr;
   logic [EW-1:0]           ram_wr_data;
   logic                    ram_rd_en;
   logic [AW-1:0]           ram_rd_addr;
   logic [EW-1:0]           ram_rd_data;

   entry_type               rd_e;
   entry_type               wr_e;
   logic                    req_fire;
   logic [OPCODE_W-1:0]     req_op;
   logic [SIZE_W-1:0]       req_size;
   logic [ID_W-1:0]         req_id;
   logic [SHIFT_W-1:0]      sh;
   logic [LW-1:0]           region_len;
   logic [LW-1:0]           u;
   logic [LW-1:0]           s_next;
   logic                    cand;
   logic                    better;
   logic                    rd_free;
   logic [47:0]             off_full;
   logic [SIZE_W:0]         size_up;
   logic [ID_W:0]           id_wide;

   bfsa_slot_ram #(
      .DEPTH (MAX_SLOTS),
      .WIDTH (EW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = req_tdata[2:0];
   assign req_size   = req_tdata[34:3];
   assign req_id     = req_tdata[66:35];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rd_e       = entry_type'(ram_rd_data);
   assign ram_wr_data = EW'(wr_e);

   // slot size clipped to the supported range
   assign sh = (slot_shift_ff > SHIFT_W'(SHIFT_MAX)) ? SHIFT_W'(SHIFT_MAX) : slot_shift_ff;
   assign region_len = (32'(total_units_ff) > 32'(MAX_SLOTS)) ? LW'(MAX_SLOTS)
                                                              : LW'(total_units_ff);
   assign size_up  = (SIZE_W+1)'(req_size) + ((SIZE_W+1)'(1) << sh) - (SIZE_W+1)'(1);
   assign id_wide  = (ID_W+1)'(req_id);
   assign u        = units_ff[LW-1:0];
   assign rd_free  = !rd_e.alloc && (rd_e.use_cnt == '0);
   assign cand     = rd_e.head && rd_e.infree && ((SIZE_W+1)'(rd_e.len) >= units_ff);
   assign better   = !found_ff || (rd_e.len < best_ff.len) ||
                     ((rd_e.len == best_ff.len) && (rd_e.stamp < best_ff.stamp));
   assign s_next   = s_ff + rd_e.len;
   assign off_full = 48'(best_idx_ff) << sh;

   always_comb begin
      state_in       = state_ff;
      slot_shift_in  = slot_shift_ff;
      total_units_in = total_units_ff;
      stamp_in       = stamp_ff;
      idx_in         = idx_ff;
      sweep_rsp_in   = sweep_rsp_ff;
      units_in       = units_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_in        = best_ff;
      ns_in          = ns_ff;
      op_in          = op_ff;
      slot_in        = slot_ff;
      s_in           = s_ff;
      nx_in          = nx_ff;
      acc_in         = acc_ff;
      merged_in      = merged_ff;
      res_status_in  = res_status_ff;
      res_gid_in     = res_gid_ff;
      res_off_in     = res_off_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = '0;
      wr_e           = '0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = '0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_SLOT_SHIFT:  slot_shift_in  = csr_wdata[SHIFT_W-1:0];
            CSR_TOTAL_UNITS: total_units_in = csr_wdata[TOTAL_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_SWEEP: begin
            // region rebuilt as one free block at slot 0, unless it is empty
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            if ((idx_ff == '0) && (region_len != '0)) begin
               wr_e.head   = 1'b1;
               wr_e.infree = 1'b1;
               wr_e.len    = region_len;
            end
            if (idx_ff == AW'(MAX_SLOTS - 1)) begin
               stamp_in      = STAMP_W'(1);
               res_status_in = ST_OK;
               state_in      = sweep_rsp_ff ? S_DONE : S_IDLE;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               res_status_in = ST_OK;
               res_gid_in    = '0;
               res_off_in    = '0;
               unique case (opcode_type'(req_op))
                  OP_ALLOCATE: begin
                     if (req_size == '0) begin
                        res_status_in = ST_ZERO_SIZE;
                        state_in      = S_DONE;
                     end else begin
                        units_in    = size_up >> sh;
                        found_in    = 1'b0;
                        idx_in      = '0;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  OP_RETIRE, OP_ACQUIRE, OP_RELEASE: begin
                     op_in = opcode_type'(req_op);
                     if ((req_id == '0) || (id_wide > (ID_W+1)'(MAX_SLOTS))) begin
                        res_status_in = ST_INVALID_ID;
                        state_in      = S_DONE;
                     end else begin
                        slot_in     = AW'(req_id - ID_W'(1));
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(req_id - ID_W'(1));
                        state_in    = S_ID;
                     end
                  end
                  OP_COALESCE: begin
                     s_in        = '0;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     state_in    = S_COAL_S;
                  end
                  OP_CLEAR: begin
                     idx_in       = '0;
                     sweep_rsp_in = 1'b1;
                     state_in     = S_SWEEP;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            // entry idx_ff on the read port
            if (cand && better) begin
               found_in    = 1'b1;
               best_idx_in = idx_ff;
               best_in     = rd_e;
            end
            if (idx_ff == AW'(MAX_SLOTS - 1)) begin
               state_in = S_ALLOC_BEST;
            end else begin
               idx_in      = idx_ff + AW'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + AW'(1);
            end
         end
         S_ALLOC_BEST: begin
            if (!found_ff) begin
               res_status_in = ST_REALLOC;
               state_in      = S_DONE;
            end else begin
               wr_e        = best_ff;
               wr_e.infree = 1'b0;
               wr_e.alloc  = 1'b1;
               ram_wr_en   = 1'b1;
               ram_wr_addr = best_idx_ff;
               res_gid_in  = GID_W'(32'(best_idx_ff) + 32'd1);
               res_off_in  = off_full[OFFSET_W-1:0];
               ns_in       = LW'(best_idx_ff) + u;
               state_in    = S_DONE;
               if (best_ff.len > u) begin
                  wr_e.len = u;
                  if ((LW'(best_idx_ff) + u) < LW'(MAX_SLOTS)) begin
                     state_in = S_ALLOC_SPLIT;
                  end
               end
            end
         end
         S_ALLOC_SPLIT: begin
            // remainder becomes a new free-listed block
            wr_e.head   = 1'b1;
            wr_e.infree = 1'b1;
            wr_e.len    = best_ff.len - u;
            wr_e.stamp  = stamp_ff;
            stamp_in    = stamp_ff + STAMP_W'(1);
            ram_wr_en   = 1'b1;
            ram_wr_addr = ns_ff[AW-1:0];
            state_in    = S_DONE;
         end
         S_ID: begin
            state_in = S_DONE;
            wr_e     = rd_e;
            if (!rd_e.head) begin
               res_status_in = ST_INVALID_ID;
            end else begin
               unique case (op_ff)
                  OP_RETIRE: begin
                     wr_e.alloc = 1'b0;
                     ram_wr_en  = 1'b1;
                  end
                  OP_ACQUIRE: begin
                     if (rd_e.use_cnt != '1) begin
                        wr_e.use_cnt = rd_e.use_cnt + COUNT_WIDTH'(1);
                     end
                     ram_wr_en = 1'b1;
                  end
                  OP_RELEASE: begin
                     if (rd_e.use_cnt == '0) begin
                        res_status_in = ST_COUNT_ZERO;
                     end else begin
                        wr_e.use_cnt = rd_e.use_cnt - COUNT_WIDTH'(1);
                        ram_wr_en    = 1'b1;
                     end
                  end
                  default: ;
               endcase
               ram_wr_addr = slot_ff;
            end
         end
         S_COAL_S: begin
            // block at s_ff on the read port
            if (!rd_e.head || (rd_e.len == '0)) begin
               state_in = S_DONE;
            end else if (!rd_free) begin
               s_in = s_next;
               if (s_next < LW'(MAX_SLOTS)) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = s_next[AW-1:0];
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               best_in   = rd_e;
               acc_in    = rd_e.len;
               merged_in = 1'b0;
               nx_in     = s_next;
               if (s_next < LW'(MAX_SLOTS)) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = s_next[AW-1:0];
                  state_in    = S_COAL_NX;
               end else begin
                  state_in = S_COAL_FIN;
               end
            end
         end
         S_COAL_NX: begin
            // following block at nx_ff; absorb it while free
            if (rd_e.head && (rd_e.len != '0) && rd_free) begin
               merged_in    = 1'b1;
               acc_in       = acc_ff + rd_e.len;
               wr_e         = rd_e;
               wr_e.head    = 1'b0;
               wr_e.len     = '0;
               wr_e.infree  = 1'b0;
               wr_e.stamp   = '0;
               ram_wr_en    = 1'b1;
               ram_wr_addr  = nx_ff[AW-1:0];
               nx_in        = nx_ff + rd_e.len;
               if ((nx_ff + rd_e.len) < LW'(MAX_SLOTS)) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = AW'(nx_ff + rd_e.len);
               end else begin
                  state_in = S_COAL_FIN;
               end
            end else begin
               state_in = S_COAL_FIN;
            end
         end
         S_COAL_FIN: begin
            wr_e        = best_ff;
            wr_e.len    = acc_ff;
            ram_wr_en   = 1'b1;
            ram_wr_addr = s_ff[AW-1:0];
            if (!best_ff.infree || merged_ff) begin
               wr_e.infree = 1'b1;
               wr_e.stamp  = stamp_ff;
               stamp_in    = stamp_ff + STAMP_W'(1);
            end
            s_in = nx_ff;
            if (nx_ff < LW'(MAX_SLOTS)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = nx_ff[AW-1:0];
               state_in    = S_COAL_S;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({res_off_ff, res_gid_ff, res_status_ff});
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_SWEEP;
         slot_shift_ff  <= '0;
         total_units_ff <= TOTAL_W'(256);
         stamp_ff       <= STAMP_W'(1);
         idx_ff         <= '0;
         sweep_rsp_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         slot_shift_ff  <= slot_shift_in;
         total_units_ff <= total_units_in;
         stamp_ff       <= stamp_in;
         idx_ff         <= idx_in;
         sweep_rsp_ff   <= sweep_rsp_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      units_ff      <= units_in;
      found_ff      <= found_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      ns_ff         <= ns_in;
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      s_ff          <= s_in;
      nx_ff         <= nx_in;
      acc_ff        <= acc_in;
      merged_ff     <= merged_in;
      res_status_ff <= res_status_in;
      res_gid_ff    <= res_gid_in;
      res_off_ff    <= res_off_in;
      rsp_data_ff   <= rsp_data_in;
   end

   `BFSA_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "accepted beat did not make the block busy")
   `BFSA_ASSERT_IMP(a_no_rw_collision, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr, "read and write of the same slot in one cycle")
   `BFSA_ASSERT_IMP(a_grant_is_ok, rsp_tvalid && (rsp_tdata[11:3] != 9'd0), rsp_tdata[2:0] == ST_OK, "grant with an error status")

endmodule

[sim/testbench.sv]
// self-checking testbench for the best-fit slot allocator core
module testbench;
   import bfsa_pkg::*;

   localparam int NSLOT       = 256;
   localparam int CNT_MAX     = 65535;
   localparam int CYCLE_LIMIT = 3000000;

   logic                     clock;
   logic                     reset;
   logic [REQ_DATA_W-1:0]    req_tdata;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [RSP_DATA_W-1:0]    rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic                     csr_we;
   logic [CSR_INDEX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;

   best_fit_slot_allocator_core uut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // one expected response beat
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [GID_W-1:0]    gid;
      logic [OFFSET_W-1:0] offset;
   } grant_type;

   grant_type expected_grants[$];
   int     mismatches;
   int     cycle_count;
   bit     stall_on;   // when clear, neither side inserts gaps

   // shadow of the slot table
   bit              sh_head[NSLOT];
   int unsigned     sh_len[NSLOT];
   bit              sh_alloc[NSLOT];
   bit              sh_listed[NSLOT];
   int unsigned     sh_count[NSLOT];
   logic [31:0]     sh_stamp[NSLOT];
   logic [31:0]     sh_stamp_next;
   logic [SHIFT_W-1:0] sh_shift;
   logic [TOTAL_W-1:0] sh_total;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic push_free(input int s);
      sh_listed[s]  = 1'b1;
      sh_stamp[s]   = sh_stamp_next;
      sh_stamp_next = sh_stamp_next + 32'd1;
   endtask

   task automatic rebuild_table();
      int n;
      n = (sh_total > NSLOT) ? NSLOT : sh_total;
      for (int i = 0; i < NSLOT; i++) begin
         sh_head[i] = 0; sh_len[i] = 0; sh_alloc[i] = 0;
         sh_listed[i] = 0; sh_count[i] = 0; sh_stamp[i] = '0;
      end
      sh_stamp_next = 32'd1;
      if (n > 0) begin
         sh_head[0] = 1; sh_len[0] = n; sh_listed[0] = 1;
      end
   endtask

   function automatic bit slot_free(input int s);
      return !sh_alloc[s] && sh_count[s] == 0;
   endfunction

   task automatic merge_free_runs();
      int  s, nx, len;
      bit  merged;
      s = 0;
      while (s < NSLOT && sh_head[s] && sh_len[s] != 0) begin
         if (!slot_free(s)) begin
            s += sh_len[s];
            continue;
         end
         merged = 0;
         nx = s + sh_len[s];
         while (nx < NSLOT && sh_head[nx] && sh_len[nx] != 0 && slot_free(nx)) begin
            len = sh_len[nx];
            merged = 1;
            sh_len[s] += len;
            sh_head[nx] = 0; sh_len[nx] = 0; sh_listed[nx] = 0; sh_stamp[nx] = '0;
            nx += len;
         end
         if (!sh_listed[s] || merged) push_free(s);
         s = nx;
      end
   endtask

   // works out the response to one operation and updates the shadow table
   task automatic predict_grant(input logic [2:0] op, input logic [31:0] size,
                                input logic [31:0] id, output grant_type g);
      int          sh, best, slot, ns;
      bit          found;
      longint unsigned units;
      g = '0;
      sh = (sh_shift > SHIFT_MAX) ? SHIFT_MAX : sh_shift;
      slot = int'(id) - 1;
      if (op == OP_ALLOCATE) begin
         if (size == 0) begin
            g.status = ST_ZERO_SIZE;
         end else begin
            units = (longint'(size) + ((64'd1 << sh) - 1)) >> sh;
            found = 0; best = 0;
            for (int i = 0; i < NSLOT; i++) begin
               if (!sh_head[i] || !sh_listed[i] || sh_len[i] < units) continue;
               if (!found || sh_len[i] < sh_len[best] ||
                   (sh_len[i] == sh_len[best] && sh_stamp[i] < sh_stamp[best])) begin
                  best = i; found = 1;
               end
            end
            if (!found) begin
               g.status = ST_REALLOC;
            end else begin
               sh_listed[best] = 0;
               sh_alloc[best]  = 1;
               if (sh_len[best] > units) begin
                  ns = best + int'(units);
                  if (ns < NSLOT) begin
                     sh_head[ns]  = 1;
                     sh_len[ns]   = sh_len[best] - 32'(units);
                     sh_alloc[ns] = 0;
                     sh_count[ns] = 0;
                     push_free(ns);
                  end
                  sh_len[best] = 32'(units);
               end
               g.status = ST_OK;
               g.gid    = GID_W'(best + 1);
               g.offset = OFFSET_W'(longint'(best) << sh);
            end
         end
      end else if (op == OP_RETIRE || op == OP_ACQUIRE || op == OP_RELEASE) begin
         if (id == 0 || id > NSLOT || !sh_head[slot]) begin
            g.status = ST_INVALID_ID;
         end else if (op == OP_RETIRE) begin
            sh_alloc[slot] = 0;
         end else if (op == OP_ACQUIRE) begin
            if (sh_count[slot] < CNT_MAX) sh_count[slot]++;
         end else if (sh_count[slot] == 0) begin
            g.status = ST_COUNT_ZERO;
         end else begin
            sh_count[slot]--;
         end
      end else if (op == OP_COALESCE) begin
         merge_free_runs();
      end else if (op == OP_CLEAR) begin
         rebuild_table();
      end
   endtask

   // one operation beat; valid stays high when the next beat follows at once
   task automatic send_op(input logic [2:0] op, input logic [31:0] size,
                          input logic [31:0] id);
      grant_type g;
      int     gap;
      req_tdata  <= {5'd0, id, size, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_grant(op, size, id, g);
      expected_grants.push_back(g);
      gap = stall_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // waits for every response, then writes one register while idle
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      req_tvalid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_SLOT_SHIFT) sh_shift = value[SHIFT_W-1:0];
      else sh_total = value[TOTAL_W-1:0];
   endtask

   // receiver side: random stall before taking each response beat
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         n = stall_on ? $urandom_range(0, 11) : 0;
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // response checker
   always @(posedge clock) begin
      grant_type exp_g;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %h", rsp_tdata);
         end else begin
            exp_g = expected_grants.pop_front();
            if (rsp_tdata[2:0] !== exp_g.status || rsp_tdata[11:3] !== exp_g.gid ||
                rsp_tdata[35:12] !== exp_g.offset || rsp_tdata[39:36] !== 4'd0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: status %0d/%0d id %0d/%0d offset %h/%h (exp/act)",
                           exp_g.status, rsp_tdata[2:0], exp_g.gid, rsp_tdata[11:3],
                           exp_g.offset, rsp_tdata[35:12]);
            end
         end
      end
   end

   // a head id from the shadow table, or 0 if there is none
   function automatic logic [31:0] pick_head();
      int heads[$];
      for (int i = 0; i < NSLOT; i++) if (sh_head[i]) heads.push_back(i + 1);
      if (heads.size() == 0) return 32'd0;
      return 32'(heads[$urandom_range(0, heads.size() - 1)]);
   endfunction

   // extremes of the fields, every operation and the corner cases
   task automatic test_directed();
      send_op(OP_ALLOCATE, 32'd0, 32'd0);           // zero size
      send_op(OP_ALLOCATE, 32'hFFFF_FFFF, 32'd0);   // oversized, no fit
      send_op(OP_ALLOCATE, 32'd1, 32'hFFFF_FFFF);   // id 1, remainder at slot 1
      send_op(OP_ALLOCATE, 32'd3, 32'd0);           // id 2
      send_op(OP_RETIRE, 32'd0, 32'd0);             // id zero
      send_op(OP_ACQUIRE, 32'd0, 32'd257);          // out of range
      send_op(OP_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(OP_RETIRE, 32'd0, 32'd4);             // slot without head
      send_op(OP_RELEASE, 32'd0, 32'd1);            // release at zero
      send_op(OP_ACQUIRE, 32'd0, 32'd1);
      send_op(OP_RETIRE, 32'd0, 32'd1);             // retired but still in use
      send_op(OP_COALESCE, 32'd0, 32'd0);
      send_op(OP_RELEASE, 32'd0, 32'd1);
      send_op(3'd6, 32'd5, 32'd1);                  // unknown opcodes
      send_op(3'd7, 32'd0, 32'd0);
      send_op(OP_ACQUIRE, 32'd0, 32'd5);            // busy block on the free list
      send_op(OP_ALLOCATE, 32'd200, 32'd0);
      send_op(OP_RETIRE, 32'd0, 32'd2);
      send_op(OP_COALESCE, 32'd0, 32'd0);
      send_op(OP_ALLOCATE, 32'd256, 32'd0);
      send_op(OP_CLEAR, 32'd0, 32'd0);
      send_op(OP_ALLOCATE, 32'd256, 32'd0);         // whole region
      send_op(OP_CLEAR, 32'd0, 32'd0);
   endtask

   // register extremes: empty and tiny regions, widest and clamped shifts
   task automatic test_register_extremes();
      write_reg(CSR_TOTAL_UNITS, 9'd0);
      send_op(OP_CLEAR, 32'd0, 32'd0);
      send_op(OP_ALLOCATE, 32'd1, 32'd0);
      send_op(OP_COALESCE, 32'd0, 32'd0);
      write_reg(CSR_TOTAL_UNITS, 9'd1);
      send_op(OP_CLEAR, 32'd0, 32'd0);
      send_op(OP_ALLOCATE, 32'd2, 32'd0);
      send_op(OP_ALLOCATE, 32'd1, 32'd0);
      write_reg(CSR_TOTAL_UNITS, 9'h1FF);
      write_reg(CSR_SLOT_SHIFT, 5'd16);
      send_op(OP_CLEAR, 32'd0, 32'd0);
      send_op(OP_ALLOCATE, 32'h0010_0001, 32'd0);
      send_op(OP_ALLOCATE, 32'd1, 32'd0);
      write_reg(CSR_SLOT_SHIFT, 5'd31);
      send_op(OP_ALLOCATE, 32'h00E0_0000, 32'd0);  // shift clamped to 16
      send_op(OP_ALLOCATE, 32'hFFFF_FFFF, 32'd0);
      write_reg(CSR_SLOT_SHIFT, 5'd0);
      write_reg(CSR_TOTAL_UNITS, 9'd256);
      send_op(OP_CLEAR, 32'd0, 32'd0);
   endtask

   // random operations over a living table, mostly well formed
   task automatic test_random_traffic(input int count);
      int          r, sh;
      logic [2:0]  op;
      logic [31:0] size, id;
      for (int k = 0; k < count; k++) begin
         r  = $urandom_range(0, 99);
         sh = (sh_shift > SHIFT_MAX) ? SHIFT_MAX : sh_shift;
         size = $urandom_range(1, 12 << sh);
         id = pick_head();
         if (r < 38)      op = OP_ALLOCATE;
         else if (r < 52) op = OP_RETIRE;
         else if (r < 66) op = OP_ACQUIRE;
         else if (r < 80) op = OP_RELEASE;
         else if (r < 91) op = OP_COALESCE;
         else if (r < 93) op = OP_CLEAR;
         else if (r < 95) op = 3'($urandom_range(6, 7));
         else begin
            // noise: raw field values
            op   = 3'($urandom_range(0, 3));
            size = $urandom();
            id   = ($urandom_range(0, 1)) ? $urandom() : 32'($urandom_range(0, 300));
         end
         send_op(op, size, id);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatches = 0;
      cycle_count = 0;
      stall_on = 1;
      sh_shift = '0;
      sh_total = 9'd256;
      rebuild_table();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_register_extremes();

      stall_on = 0;
      test_random_traffic(60);
      stall_on = 1;
      write_reg(CSR_SLOT_SHIFT, 5'd3);
      write_reg(CSR_TOTAL_UNITS, 9'd64);
      send_op(OP_CLEAR, 32'd0, 32'd0);
      test_random_traffic(150);
      write_reg(CSR_SLOT_SHIFT, 5'd16);
      write_reg(CSR_TOTAL_UNITS, 9'd5);
      send_op(OP_CLEAR, 32'd0, 32'd0);
      test_random_traffic(80);
      write_reg(CSR_SLOT_SHIFT, 5'd0);
      write_reg(CSR_TOTAL_UNITS, 9'd256);
      send_op(OP_CLEAR, 32'd0, 32'd0);
      test_random_traffic(150);
      stall_on = 0;
      test_random_traffic(40);

      // drain
      req_tvalid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/bfsa_pkg.sv
hw/rtl/bfsa_slot_ram.sv
hw/rtl/best_fit_slot_allocator_core.sv
sim/testbench.sv
